// ===== rtl/sgs_pkg.sv =====
`default_nettype none

package sgs_pkg;

   localparam int NUM_SERVO   = 3;
   localparam int TABLE_DEPTH = 9;
   localparam int ANGLE_WIDTH = 8;
   localparam int PULSE_WIDTH = 8;
   localparam int LIGHT_WIDTH = 5;
   localparam int STEP_WIDTH  = 4;
   localparam int CODE_WIDTH  = 4;
   localparam int CHAR_WIDTH  = 8;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSE_MIN = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSE_MAX = 1'd1;

   localparam logic [PULSE_WIDTH-1:0] PULSE_MIN_RESET = 8'd8;
   localparam logic [PULSE_WIDTH-1:0] PULSE_MAX_RESET = 8'd38;

   // Item kinds.
   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_COMMAND = 1'b1;

   // Command characters that select a gait.
   localparam logic [CHAR_WIDTH-1:0] CHAR_FORWARD  = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CHAR_BACKWARD = 8'h62;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LEFT     = 8'h6C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_RIGHT    = 8'h72;

   // Servo positions in the angle and pulse vectors.
   localparam logic [1:0] SERVO_FRONT  = 2'd0;
   localparam logic [1:0] SERVO_MIDDLE = 2'd1;
   localparam logic [1:0] SERVO_REAR   = 2'd2;

   // Phase codes held in the phase table.
   localparam logic [CODE_WIDTH-1:0] PH_CENTER       = 4'd0;
   localparam logic [CODE_WIDTH-1:0] PH_MIDDLE_UP    = 4'd1;
   localparam logic [CODE_WIDTH-1:0] PH_SWING_FWD    = 4'd2;
   localparam logic [CODE_WIDTH-1:0] PH_MIDDLE_DOWN  = 4'd3;
   localparam logic [CODE_WIDTH-1:0] PH_SWING_BACK   = 4'd4;
   localparam logic [CODE_WIDTH-1:0] PH_MIDDLE_HOME  = 4'd5;
   localparam logic [CODE_WIDTH-1:0] PH_BACK_HOME    = 4'd6;
   localparam logic [CODE_WIDTH-1:0] PH_MIDDLE_RAISE = 4'd7;
   localparam logic [CODE_WIDTH-1:0] PH_FWD_HOME     = 4'd8;

   // Gait phase lists, padded to the table depth; only the first LEN entries load.
   localparam logic [STEP_WIDTH-1:0] LEN_SHORT = 4'd5;
   localparam logic [STEP_WIDTH-1:0] LEN_LONG  = 4'd9;
   localparam logic [STEP_WIDTH-1:0] LEN_OTHER = 4'd1;
   localparam int LEN_SHORT_INT = 5;
   localparam int LEN_LONG_INT  = 9;

   localparam logic [CODE_WIDTH-1:0] GAIT_FWD [TABLE_DEPTH] =
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [CODE_WIDTH-1:0] GAIT_BACK [TABLE_DEPTH] =
      '{4'd0, 4'd3, 4'd2, 4'd1, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0};
   localparam logic [CODE_WIDTH-1:0] GAIT_LEFT [TABLE_DEPTH] =
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd1, 4'd2, 4'd7, 4'd8};
   localparam logic [CODE_WIDTH-1:0] GAIT_RIGHT [TABLE_DEPTH] =
      '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6};

   localparam logic [ANGLE_WIDTH-1:0] ANGLE_HOME   = 8'd90;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_HIGH   = 8'd105;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_LOW    = 8'd75;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_REACH  = 8'd120;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_TUCK   = 8'd60;
   localparam logic [ANGLE_WIDTH-1:0] ANGLE_FULL   = 8'd180;
   localparam logic [NUM_SERVO-1:0][ANGLE_WIDTH-1:0] ANGLE_RESET = {8'd180, 8'd90, 8'd0};

   // Light bits.
   localparam logic [LIGHT_WIDTH-1:0] LIGHT_KEEP     = 5'b10000;
   localparam int LIGHT_OTHER    = 0;
   localparam int LIGHT_FORWARD  = 1;
   localparam int LIGHT_BACKWARD = 2;
   localparam int LIGHT_LEFT     = 3;
   localparam int LIGHT_RIGHT    = 4;

   // Division by 180 through a reciprocal: exact for products below 2^23 / 112.
   localparam int DEG_FULL    = 180;
   localparam int PROD_WIDTH  = 2 * ANGLE_WIDTH;
   localparam int RECIP_SHIFT = 23;
   localparam logic [PROD_WIDTH-1:0] RECIP_MULT =
      PROD_WIDTH'(((1 << RECIP_SHIFT) + DEG_FULL - 1) / DEG_FULL);

   typedef struct packed {
      logic                  func;
      logic [CHAR_WIDTH-1:0] command_char;
   } sgs_req_type;

   typedef struct packed {
      logic [PULSE_WIDTH-1:0] pulse_front;
      logic [PULSE_WIDTH-1:0] pulse_middle;
      logic [PULSE_WIDTH-1:0] pulse_rear;
      logic [LIGHT_WIDTH-1:0] led_bits;
      logic [STEP_WIDTH-1:0]  phase_step;
   } sgs_rsp_type;

   // State snapshot handed from the gait core to the pulse mapper.
   typedef struct packed {
      logic                                   tick;
      logic [NUM_SERVO-1:0][ANGLE_WIDTH-1:0] angle;
      logic [LIGHT_WIDTH-1:0]                 led;
      logic [STEP_WIDTH-1:0]                  step;
   } sgs_stage_type;

endpackage

`default_nettype wire

// ===== rtl/sgs_gait_core.sv =====
`default_nettype none

module sgs_gait_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire sgs_pkg::sgs_req_type req_payload,
   input  wire logic                stage2_ready,
   output logic                     s1_valid,
   output sgs_pkg::sgs_stage_type   s1_stage
);
   import sgs_pkg::*;

   logic [STEP_WIDTH-1:0]                  step_ff, step_in;
   logic [STEP_WIDTH-1:0]                  count_ff, count_in;
   logic [CODE_WIDTH-1:0]                  phase_tbl_ff [TABLE_DEPTH];
   logic [CODE_WIDTH-1:0]                  phase_tbl_in [TABLE_DEPTH];
   logic [NUM_SERVO-1:0][ANGLE_WIDTH-1:0] angle_ff, angle_in;
   logic [LIGHT_WIDTH-1:0]                 light_ff, light_in;
   logic [CHAR_WIDTH-1:0]                  last_ff, last_in;
   logic                                   s1_valid_ff;
   sgs_stage_type                          s1_stage_ff, s1_stage_in;

   logic                  advance_s1;
   logic                  accept;
   logic [STEP_WIDTH-1:0] cur_step;
   logic [CODE_WIDTH-1:0] code;
   logic                  adv;

   assign advance_s1 = !s1_valid_ff || stage2_ready;
   assign req_stall  = !advance_s1;
   assign accept     = req_valid && advance_s1;

   always_comb begin
      step_in      = step_ff;
      count_in     = count_ff;
      phase_tbl_in = phase_tbl_ff;
      angle_in     = angle_ff;
      light_in     = light_ff;
      last_in      = last_ff;
      cur_step     = (step_ff >= count_ff) ? 4'd1 : step_ff;
      code         = (cur_step < STEP_WIDTH'(TABLE_DEPTH)) ? phase_tbl_ff[cur_step] : PH_CENTER;
      adv          = 1'b0;
      if (accept) begin
         if (req_payload.func == FUNC_COMMAND) begin
            if (req_payload.command_char != last_ff) begin
               last_in  = req_payload.command_char;
               light_in = light_ff & LIGHT_KEEP;
               step_in  = '0;
               case (req_payload.command_char)
                  CHAR_FORWARD: begin
                     for (int i = 0; i < LEN_SHORT_INT; i++) phase_tbl_in[i] = GAIT_FWD[i];
                     count_in = LEN_SHORT;
                     light_in[LIGHT_FORWARD] = 1'b1;
                  end
                  CHAR_BACKWARD: begin
                     for (int i = 0; i < LEN_SHORT_INT; i++) phase_tbl_in[i] = GAIT_BACK[i];
                     count_in = LEN_SHORT;
                     light_in[LIGHT_BACKWARD] = 1'b1;
                  end
                  CHAR_LEFT: begin
                     for (int i = 0; i < LEN_LONG_INT; i++) phase_tbl_in[i] = GAIT_LEFT[i];
                     count_in = LEN_LONG;
                     light_in[LIGHT_LEFT] = 1'b1;
                  end
                  CHAR_RIGHT: begin
                     for (int i = 0; i < LEN_LONG_INT; i++) phase_tbl_in[i] = GAIT_RIGHT[i];
                     count_in = LEN_LONG;
                     light_in[LIGHT_RIGHT] = 1'b1;
                  end
                  default: begin
                     count_in = LEN_OTHER;
                     light_in[LIGHT_OTHER] = 1'b1;
                  end
               endcase
            end
         end else begin
            case (code)
               PH_CENTER: begin
                  angle_in = {ANGLE_HOME, ANGLE_HOME, ANGLE_HOME};
                  light_in = light_ff & LIGHT_KEEP;
                  adv      = 1'b1;
               end
               PH_MIDDLE_UP: begin
                  angle_in[SERVO_MIDDLE] = angle_ff[SERVO_MIDDLE] + 8'd1;
                  adv = angle_in[SERVO_MIDDLE] >= ANGLE_HIGH;
                  light_in[LIGHT_FORWARD] = 1'b1;
               end
               PH_SWING_FWD: begin
                  angle_in[SERVO_FRONT] = angle_ff[SERVO_FRONT] + 8'd1;
                  angle_in[SERVO_REAR]  = angle_ff[SERVO_REAR] - 8'd1;
                  adv = angle_in[SERVO_REAR] <= ANGLE_TUCK
                        && angle_in[SERVO_FRONT] >= ANGLE_REACH;
               end
               PH_MIDDLE_DOWN: begin
                  light_in = light_ff & LIGHT_KEEP;
                  angle_in[SERVO_MIDDLE] = angle_ff[SERVO_MIDDLE] - 8'd1;
                  adv = angle_in[SERVO_MIDDLE] <= ANGLE_LOW;
               end
               PH_SWING_BACK: begin
                  angle_in[SERVO_FRONT] = angle_ff[SERVO_FRONT] - 8'd1;
                  angle_in[SERVO_REAR]  = angle_ff[SERVO_REAR] + 8'd1;
                  adv = angle_in[SERVO_FRONT] <= ANGLE_TUCK
                        && angle_in[SERVO_REAR] >= ANGLE_REACH;
               end
               PH_MIDDLE_HOME: begin
                  angle_in[SERVO_MIDDLE] = angle_ff[SERVO_MIDDLE] - 8'd1;
                  adv = angle_in[SERVO_MIDDLE] <= ANGLE_HOME;
               end
               PH_BACK_HOME: begin
                  angle_in[SERVO_FRONT] = angle_ff[SERVO_FRONT] - 8'd1;
                  angle_in[SERVO_REAR]  = angle_ff[SERVO_REAR] + 8'd1;
                  adv = angle_in[SERVO_FRONT] <= ANGLE_HOME
                        && angle_in[SERVO_REAR] >= ANGLE_HOME;
               end
               PH_MIDDLE_RAISE: begin
                  angle_in[SERVO_MIDDLE] = angle_ff[SERVO_MIDDLE] + 8'd1;
                  adv = angle_in[SERVO_MIDDLE] >= ANGLE_HOME;
               end
               PH_FWD_HOME: begin
                  angle_in[SERVO_FRONT] = angle_ff[SERVO_FRONT] + 8'd1;
                  angle_in[SERVO_REAR]  = angle_ff[SERVO_REAR] - 8'd1;
                  adv = angle_in[SERVO_FRONT] >= ANGLE_HOME
                        && angle_in[SERVO_REAR] <= ANGLE_HOME;
               end
               default: adv = 1'b1;
            endcase
            step_in = adv ? cur_step + 4'd1 : cur_step;
         end
      end
   end

   always_comb begin
      s1_stage_in.tick  = (req_payload.func == FUNC_TICK);
      s1_stage_in.angle = angle_in;
      s1_stage_in.led   = light_in;
      s1_stage_in.step  = step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         count_ff    <= '0;
         angle_ff    <= ANGLE_RESET;
         light_ff    <= '0;
         last_ff     <= '0;
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) phase_tbl_ff[i] <= '0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         angle_ff     <= angle_in;
         light_ff     <= light_in;
         last_ff      <= last_in;
         phase_tbl_ff <= phase_tbl_in;
         if (advance_s1) begin
            s1_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stage_ff <= s1_stage_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_stage = s1_stage_ff;

   // Table entry zero is always a centering phase, so a tick never leaves step zero.
   a_tick_leaves_zero: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.func == FUNC_TICK |=> step_ff != '0)
      else $error("step index is zero after a tick");

   a_repeat_ignored: assert property (@(posedge clock) disable iff (reset)
      accept && req_payload.func == FUNC_COMMAND && req_payload.command_char == last_ff
      |=> $stable(step_ff) && $stable(count_ff) && $stable(light_ff))
      else $error("repeated command character changed the sequencer");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      count_ff == 4'd0 || count_ff == LEN_OTHER || count_ff == LEN_SHORT
      || count_ff == LEN_LONG)
      else $error("phase count holds an impossible length");

endmodule

`default_nettype wire

// ===== rtl/sgs_pulse_map.sv =====
`default_nettype none

module sgs_pulse_map (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  s1_valid,
   input  wire sgs_pkg::sgs_stage_type s1_stage,
   input  wire logic [sgs_pkg::PULSE_WIDTH-1:0] pulse_min,
   input  wire logic [sgs_pkg::PULSE_WIDTH-1:0] pulse_max,
   output logic                       stage2_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output sgs_pkg::sgs_rsp_type       rsp_payload
);
   import sgs_pkg::*;

   localparam int WIDE_WIDTH = 2 * PROD_WIDTH;

   logic                                   s2_valid_ff;
   logic                                   s2_tick_ff;
   logic [NUM_SERVO-1:0]                   s2_in_range_ff, s2_in_range_in;
   logic [NUM_SERVO-1:0][PROD_WIDTH-1:0]  s2_prod_ff, s2_prod_in;
   logic [LIGHT_WIDTH-1:0]                 s2_led_ff;
   logic [STEP_WIDTH-1:0]                  s2_step_ff;

   logic                                   rsp_valid_ff;
   logic [NUM_SERVO-1:0][PULSE_WIDTH-1:0] pulse_ff, pulse_in;
   logic [LIGHT_WIDTH-1:0]                 led_ff;
   logic [STEP_WIDTH-1:0]                  step_ff;

   logic                   advance_out;
   logic                   advance_s2;
   logic [PULSE_WIDTH-1:0] span;
   logic [NUM_SERVO-1:0][WIDE_WIDTH-1:0]  scaled;

   assign advance_out  = !rsp_valid_ff || !rsp_stall;
   assign advance_s2   = !s2_valid_ff || advance_out;
   assign stage2_ready = advance_s2;

   assign span = (pulse_max >= pulse_min) ? pulse_max - pulse_min : '0;

   always_comb begin
      for (int k = 0; k < NUM_SERVO; k++) begin
         s2_in_range_in[k] = s1_stage.angle[k] <= ANGLE_FULL;
         s2_prod_in[k]     = PROD_WIDTH'(s1_stage.angle[k]) * PROD_WIDTH'(span);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_SERVO; k++) begin
         scaled[k] = WIDE_WIDTH'(s2_prod_ff[k]) * WIDE_WIDTH'(RECIP_MULT);
         if (s2_tick_ff && s2_in_range_ff[k]) begin
            pulse_in[k] = scaled[k][RECIP_SHIFT +: PULSE_WIDTH] + pulse_min;
         end else begin
            pulse_in[k] = pulse_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pulse_ff     <= '0;
      end else begin
         if (advance_s2) begin
            s2_valid_ff <= s1_valid;
         end
         if (advance_out) begin
            rsp_valid_ff <= s2_valid_ff;
            if (s2_valid_ff) begin
               pulse_ff <= pulse_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance_s2 && s1_valid) begin
         s2_tick_ff     <= s1_stage.tick;
         s2_in_range_ff <= s2_in_range_in;
         s2_prod_ff     <= s2_prod_in;
         s2_led_ff      <= s1_stage.led;
         s2_step_ff     <= s1_stage.step;
      end
      if (advance_out && s2_valid_ff) begin
         led_ff  <= s2_led_ff;
         step_ff <= s2_step_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_payload.pulse_front  = pulse_ff[SERVO_FRONT];
      rsp_payload.pulse_middle = pulse_ff[SERVO_MIDDLE];
      rsp_payload.pulse_rear   = pulse_ff[SERVO_REAR];
      rsp_payload.led_bits     = led_ff;
      rsp_payload.phase_step   = step_ff;
   end

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !advance_out |=> s2_valid_ff)
      else $error("middle stage dropped an item while the output was blocked");

   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !s2_valid_ff |=> !rsp_valid_ff)
      else $error("result repeated after its transfer");

endmodule

`default_nettype wire

// ===== rtl/servo_gait_sequencer.sv =====
`default_nettype none

// Three-servo walking gait sequencer. Each input transfer is either a command
// character (func = 1) that selects a gait and sets the indicator lights, or a
// gait tick (func = 0) that steps the current phase of the loaded sequence, moves the
// servo angles and recomputes the three servo compare values. Every input
// transfer yields exactly one result transfer, carrying the compare values,
// lights and step index as they stand after that item. The block takes one
// item per clock cycle while the result side is not stalling. Each result
// passes through three registers: the first holds the updated gait state, the
// second the angle-times-span product, and the output register the compare value
// after scaling by 1/180 with a reciprocal multiply. Input is stalled only when all
// three registers are full and the result side is stalling. The pulse_min and
// pulse_max registers are written over the csr_ port, which is always ready;
// write them only while no item is in flight.
module servo_gait_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire sgs_pkg::sgs_req_type                req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output sgs_pkg::sgs_rsp_type                     rsp_payload,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sgs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sgs_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import sgs_pkg::*;

   logic [PULSE_WIDTH-1:0] pulse_min_ff;
   logic [PULSE_WIDTH-1:0] pulse_max_ff;

   logic          s1_valid;
   sgs_stage_type s1_stage;
   logic          stage2_ready;

   // Configuration writes go straight into the registers, so the port never pushes back.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_min_ff <= PULSE_MIN_RESET;
         pulse_max_ff <= PULSE_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PULSE_MIN: pulse_min_ff <= PULSE_WIDTH'(csr_data);
            CSR_PULSE_MAX: pulse_max_ff <= PULSE_WIDTH'(csr_data);
            default: ;
         endcase
      end
   end

   // Gait state: commands, phase table, step counter, angles and lights.
   sgs_gait_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .stage2_ready (stage2_ready),
      .s1_valid     (s1_valid),
      .s1_stage     (s1_stage)
   );

   // Angle to compare-value mapping and the result register.
   sgs_pulse_map u_map (
      .clock        (clock),
      .reset        (reset),
      .s1_valid     (s1_valid),
      .s1_stage     (s1_stage),
      .pulse_min    (pulse_min_ff),
      .pulse_max    (pulse_max_ff),
      .stage2_ready (stage2_ready),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire
